// File: sv/kclc_pkg.sv
// Shared types, codes and the key table for the keypad code lock controller.
// No dependencies; every other file of the block depends on this package.
package kclc_pkg;

  localparam int KEY_W   = 5;
  localparam int DIGIT_W = 4;
  localparam int EVENT_W = 4;
  localparam int COUNT_W = 3;
  localparam int MODE_W  = 2;

  // Lock modes.
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VERIFY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OLD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEW    = 2'd3;

  // Result events.
  localparam logic [EVENT_W-1:0] EV_IGNORED    = 4'd0;
  localparam logic [EVENT_W-1:0] EV_BEEP       = 4'd1;
  localparam logic [EVENT_W-1:0] EV_VERIFY_ASK = 4'd2;
  localparam logic [EVENT_W-1:0] EV_OLD_ASK    = 4'd3;
  localparam logic [EVENT_W-1:0] EV_ADDED      = 4'd4;
  localparam logic [EVENT_W-1:0] EV_REMOVED    = 4'd5;
  localparam logic [EVENT_W-1:0] EV_UNLOCK     = 4'd6;
  localparam logic [EVENT_W-1:0] EV_ERROR      = 4'd7;
  localparam logic [EVENT_W-1:0] EV_NEW_ASK    = 4'd8;
  localparam logic [EVENT_W-1:0] EV_CHANGED    = 4'd9;

  // Idle-mode digits that open an entry.
  localparam logic [DIGIT_W-1:0] DIGIT_VERIFY = 4'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_CHANGE = 4'd2;

  typedef enum logic [2:0] {
    KC_NONE,
    KC_DIGIT,
    KC_SAVE,
    KC_BACK,
    KC_OTHER
  } key_kind_t;

  typedef struct packed {
    key_kind_t           kind;
    logic [DIGIT_W-1:0]  digit;
  } key_t;

  // Key table "0123456789S0QU00D00T00A"; indices past its end decode as none.
  function automatic key_t key_decode(input logic [KEY_W-1:0] idx);
    key_t k;
    k.kind  = KC_NONE;
    k.digit = '0;
    unique case (idx) inside
      [5'd0:5'd9]: begin
        k.kind  = KC_DIGIT;
        k.digit = idx[DIGIT_W-1:0];
      end
      5'd11, 5'd14, 5'd15, 5'd17, 5'd18, 5'd20, 5'd21: begin
        k.kind = KC_DIGIT;
      end
      5'd10: begin
        k.kind = KC_SAVE;
      end
      5'd19: begin
        k.kind = KC_BACK;
      end
      5'd12, 5'd13, 5'd16, 5'd22: begin
        k.kind = KC_OTHER;
      end
      default: begin
        k.kind = KC_NONE;
      end
    endcase
    return k;
  endfunction

endpackage

// File: sv/kclc_if.sv
// Valid/ready channel interfaces for key presses and lock results.
// Depends on kclc_pkg for the field widths.
interface kclc_in_if;
  logic                       valid;
  logic                       ready;
  logic [kclc_pkg::KEY_W-1:0] key_index;

  modport source (output valid, output key_index, input ready);
  modport sink (input valid, input key_index, output ready);
endinterface

interface kclc_out_if;
  logic                         valid;
  logic                         ready;
  logic [kclc_pkg::EVENT_W-1:0] event_res;
  logic [kclc_pkg::COUNT_W-1:0] entry_count;
  logic [kclc_pkg::MODE_W-1:0]  lock_mode;

  modport source (output valid, output event_res, output entry_count, output lock_mode,
                  input ready);
  modport sink (input valid, input event_res, input entry_count, input lock_mode,
                output ready);
endinterface

// File: sv/kclc_front.sv
// Front end: accepts key presses, classifies them through the key table and
// holds the classified keys in a two-entry queue. Depends on kclc_pkg, kclc_if.
module kclc_front (
  input  logic            clk,
  input  logic            rst_n,
  kclc_in_if.sink         in_ch,
  output logic            q_valid,
  input  logic            q_pop,
  output kclc_pkg::key_t  q_key
);
  import kclc_pkg::*;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  key_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign in_ch.ready = (count_r != QUEUE_DEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_key       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= key_decode(in_ch.key_index);
    end
  end

endmodule

// File: sv/kclc_back.sv
// Back end: runs the lock state machine on classified keys, keeps the entry
// buffer and stored code, and registers the result. Depends on kclc_pkg, kclc_if.
module kclc_back #(
  parameter int CODE_LENGTH = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  kclc_pkg::key_t  q_key,
  kclc_out_if.source      out_ch
);
  import kclc_pkg::*;

  localparam int LEN_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = $clog2(CODE_LENGTH);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CODE_LENGTH);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [DIGIT_W-1:0] entry_r  [CODE_LENGTH];
  logic [DIGIT_W-1:0] stored_r [CODE_LENGTH];

  logic               out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0] event_r, event_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [MODE_W-1:0]  lmode_r;

  logic match;
  logic digit_we;
  logic code_we;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entry_r[i] != stored_r[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    event_nxt = EV_IGNORED;
    digit_we  = 1'b0;
    code_we   = 1'b0;
    if (q_key.kind == KC_NONE) begin
      event_nxt = EV_IGNORED;
    end else if (mode_r == MODE_IDLE) begin
      if (q_key.kind == KC_DIGIT && q_key.digit == DIGIT_VERIFY) begin
        mode_nxt  = MODE_VERIFY;
        len_nxt   = '0;
        event_nxt = EV_VERIFY_ASK;
      end else if (q_key.kind == KC_DIGIT && q_key.digit == DIGIT_CHANGE) begin
        mode_nxt  = MODE_OLD;
        len_nxt   = '0;
        event_nxt = EV_OLD_ASK;
      end else begin
        event_nxt = EV_BEEP;
      end
    end else begin
      case (q_key.kind)
        KC_DIGIT: begin
          if (len_r != FULL_LEN) begin
            digit_we  = 1'b1;
            len_nxt   = len_r + LEN_W'(1);
            event_nxt = EV_ADDED;
          end
        end
        KC_BACK: begin
          if (len_r != '0) begin
            len_nxt   = len_r - LEN_W'(1);
            event_nxt = EV_REMOVED;
          end
        end
        KC_SAVE: begin
          if (len_r == FULL_LEN) begin
            len_nxt = '0;
            unique case (mode_r)
              MODE_VERIFY: begin
                event_nxt = match ? EV_UNLOCK : EV_ERROR;
                mode_nxt  = MODE_IDLE;
              end
              MODE_OLD: begin
                event_nxt = match ? EV_NEW_ASK : EV_ERROR;
                mode_nxt  = match ? MODE_NEW : MODE_IDLE;
              end
              default: begin
                code_we   = 1'b1;
                event_nxt = EV_CHANGED;
                mode_nxt  = MODE_IDLE;
              end
            endcase
          end
        end
        default: begin
          event_nxt = EV_IGNORED;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
        if (code_we) begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            stored_r[i] <= entry_r[i];
          end
        end
      end
    end
  end

  // The entry buffer is only read at positions written during the current entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (q_pop && digit_we && len_r[IDX_W-1:0] == IDX_W'(i)) begin
        entry_r[i] <= q_key.digit;
      end
    end
    if (q_pop) begin
      event_r <= event_nxt;
      count_r <= len_nxt[COUNT_W-1:0];
      lmode_r <= mode_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = event_r;
  assign out_ch.entry_count = count_r;
  assign out_ch.lock_mode   = lmode_r;

endmodule

// File: sv/keypad_code_lock_controller_core.sv
// Keypad code lock controller.
// in_ch carries one key press per transfer (key_index into the key table);
// out_ch returns exactly one result per key: event, digits held in the entry
// buffer (low three bits) and the lock mode after the key.
// The front end classifies each key and writes it to a two-entry queue; the
// back end runs the lock state machine and registers the result.
// Throughput is one key per cycle while out_ch is not stalled, set by the
// combinational state update of the back end, which includes the parallel compare
// of the entry against the code. out_ch.valid rises when the back end pops the key.
// When out_ch.ready is low the result register holds its value, the queue fills
// and in_ch.ready drops after three keys are in flight; no key is lost.
// Reset (rst_n low at a clock edge) empties the queue and result register,
// returns to idle with an empty entry and sets the stored code to all zeros.
// Depends on kclc_pkg, kclc_if, kclc_front and kclc_back.
module keypad_code_lock_controller_core #(
  parameter int CODE_LENGTH = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  kclc_in_if.sink     in_ch,
  kclc_out_if.source  out_ch
);
  import kclc_pkg::*;

  logic q_valid;
  logic q_pop;
  key_t q_key;

  kclc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_key   (q_key)
  );

  kclc_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_key   (q_key),
    .out_ch  (out_ch)
  );

endmodule

// File: sv/kclc_checker.sv
// Port-level checks for the keypad code lock controller, bound to the top level.
// Depends on kclc_pkg and keypad_code_lock_controller_core.
module kclc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [kclc_pkg::EVENT_W-1:0] event_res,
  input logic [kclc_pkg::COUNT_W-1:0] entry_count,
  input logic [kclc_pkg::MODE_W-1:0]  lock_mode
);
  import kclc_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(event_res) && $stable(entry_count) && $stable(lock_mode))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A successful check or a change returns to idle with an empty entry.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_UNLOCK || event_res == EV_CHANGED) |->
      lock_mode == MODE_IDLE && entry_count == '0)
    else $error("finished entry not back in idle");

  // The verify prompt opens verify mode with an empty entry.
  a_prompt_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_VERIFY_ASK |-> lock_mode == MODE_VERIFY && entry_count == '0)
    else $error("verify prompt in wrong mode");

  // Digits are only added or removed while an entry is open.
  a_digit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_ADDED || event_res == EV_REMOVED) |->
      lock_mode != MODE_IDLE)
    else $error("digit taken in idle");

endmodule

bind keypad_code_lock_controller_core kclc_checker u_kclc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_res   (out_ch.event_res),
  .entry_count (out_ch.entry_count),
  .lock_mode   (out_ch.lock_mode)
);

// File: test/kclc_lock_checker.sv
`timescale 1ns / 100ps
// Checker for the keypad code lock controller: watches both channels, predicts the
// result of every accepted key press and compares it with what the block returns.
// Depends on kclc_pkg for widths, modes and event codes.
module kclc_lock_checker #(
  parameter int CODE_LENGTH = 6
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic [kclc_pkg::KEY_W-1:0]              in_key_index,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic [kclc_pkg::EVENT_W-1:0]            out_event_res,
  input  logic [kclc_pkg::COUNT_W-1:0]            out_entry_count,
  input  logic [kclc_pkg::MODE_W-1:0]             out_lock_mode,
  output int                                      fail_count,
  output int                                      results_owed,
  output int                                      acted_keys,
  output logic [kclc_pkg::MODE_W-1:0]             cur_mode,
  output int                                      held_digits,
  output logic [CODE_LENGTH*kclc_pkg::DIGIT_W-1:0] lock_code
);
  import kclc_pkg::*;

  localparam int TABLE_LEN = 23;
  localparam logic [8*TABLE_LEN-1:0] KEY_CHARS = "0123456789S0QU00D00T00A";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_SAVE = "S";
  localparam logic [7:0] CH_BACK = "T";

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [COUNT_W-1:0] entry_count;
    logic [MODE_W-1:0]  lock_mode;
  } lock_result_t;

  lock_result_t                   owed_results[$];
  logic [CODE_LENGTH*DIGIT_W-1:0] entry_vec;

  // First character of the string sits in the top byte.
  function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
    return KEY_CHARS[8*(TABLE_LEN-1-int'(idx)) +: 8];
  endfunction

  task automatic apply_key(input logic [KEY_W-1:0] idx, output lock_result_t res);
    logic [7:0]         ch;
    logic [EVENT_W-1:0] ev;
    ev = EV_IGNORED;
    if (int'(idx) < TABLE_LEN) begin
      ch = key_char(idx);
      if (cur_mode == MODE_IDLE) begin
        if (ch == CH_ZERO + DIGIT_VERIFY) begin
          cur_mode = MODE_VERIFY;
          held_digits = 0;
          ev = EV_VERIFY_ASK;
        end else if (ch == CH_ZERO + DIGIT_CHANGE) begin
          cur_mode = MODE_OLD;
          held_digits = 0;
          ev = EV_OLD_ASK;
        end else begin
          ev = EV_BEEP;
        end
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (held_digits < CODE_LENGTH) begin
          entry_vec[held_digits*DIGIT_W +: DIGIT_W] = DIGIT_W'(ch - CH_ZERO);
          held_digits++;
          ev = EV_ADDED;
        end
      end else if (ch == CH_BACK) begin
        if (held_digits > 0) begin
          held_digits--;
          ev = EV_REMOVED;
        end
      end else if (ch == CH_SAVE && held_digits == CODE_LENGTH) begin
        case (cur_mode)
          MODE_VERIFY: begin
            ev = (entry_vec == lock_code) ? EV_UNLOCK : EV_ERROR;
            cur_mode = MODE_IDLE;
          end
          MODE_OLD: begin
            if (entry_vec == lock_code) begin
              ev = EV_NEW_ASK;
              cur_mode = MODE_NEW;
            end else begin
              ev = EV_ERROR;
              cur_mode = MODE_IDLE;
            end
          end
          default: begin
            lock_code = entry_vec;
            ev = EV_CHANGED;
            cur_mode = MODE_IDLE;
          end
        endcase
        held_digits = 0;
      end
    end
    res.event_res   = ev;
    res.entry_count = COUNT_W'(held_digits);
    res.lock_mode   = cur_mode;
  endtask

  always @(posedge clk) begin : watch
    lock_result_t got;
    lock_result_t want;
    lock_result_t fresh;
    if (!rst_n) begin
      owed_results.delete();
      cur_mode     = MODE_IDLE;
      held_digits  = 0;
      entry_vec    = '0;
      lock_code    = '0;
      fail_count   = 0;
      acted_keys   = 0;
      results_owed = 0;
    end else begin
      // Compare before predicting: a result can never belong to a key taken at this edge.
      if (out_valid && out_ready) begin
        got = '{out_event_res, out_entry_count, out_lock_mode};
        if (owed_results.size() == 0) begin
          $error("unexpected result: event_res=%0d entry_count=%0d lock_mode=%0d",
                 got.event_res, got.entry_count, got.lock_mode);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
          if (got.lock_mode !== want.lock_mode) begin
            $error("lock_mode: expected %0d, got %0d", want.lock_mode, got.lock_mode);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_key(in_key_index, fresh);
        owed_results.push_back(fresh);
        if (fresh.event_res != EV_IGNORED) begin
          acted_keys++;
        end
      end
      results_owed = owed_results.size();
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Top of the keypad code lock testbench: clock, reset, key press stimulus and the verdict.
// Depends on kclc_pkg, kclc_if, keypad_code_lock_controller_core and kclc_lock_checker.
module tb_top;
  import kclc_pkg::*;

  localparam int CODE_LENGTH = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int STALL_CYCLES = 150;

  localparam logic [KEY_W-1:0] KEY_VERIFY = 5'd1;
  localparam logic [KEY_W-1:0] KEY_CHANGE = 5'd2;
  localparam logic [KEY_W-1:0] KEY_SAVE   = 5'd10;
  localparam logic [KEY_W-1:0] KEY_BACK   = 5'd19;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct = 18;
  int recv_idle_pct = 55;
  logic stall_go = 1'b0;
  logic stall_done = 1'b0;
  int quiet_cycles = 0;

  int                             fail_count;
  int                             results_owed;
  int                             acted_keys;
  logic [MODE_W-1:0]              chk_mode;
  int                             chk_held;
  logic [CODE_LENGTH*DIGIT_W-1:0] chk_code;

  always #4 clk = ~clk;

  kclc_in_if  in_ch ();
  kclc_out_if out_ch ();

  keypad_code_lock_controller_core #(.CODE_LENGTH(CODE_LENGTH)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  kclc_lock_checker #(.CODE_LENGTH(CODE_LENGTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_key_index   (in_ch.key_index),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_event_res  (out_ch.event_res),
    .out_entry_count(out_ch.entry_count),
    .out_lock_mode  (out_ch.lock_mode),
    .fail_count     (fail_count),
    .results_owed   (results_owed),
    .acted_keys     (acted_keys),
    .cur_mode       (chk_mode),
    .held_digits    (chk_held),
    .lock_code      (chk_code)
  );

  // Zero has eight keys in the table; pick any of them.
  function automatic logic [KEY_W-1:0] digit_key(input logic [DIGIT_W-1:0] d);
    if (d != '0) begin
      return KEY_W'(d);
    end
    case ($urandom_range(7))
      0: return 5'd0;
      1: return 5'd11;
      2: return 5'd14;
      3: return 5'd15;
      4: return 5'd17;
      5: return 5'd18;
      6: return 5'd20;
      default: return 5'd21;
    endcase
  endfunction

  // Steers toward complete entries, mostly of the current code, so that unlock,
  // error, new-code and changed events all come up often.
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return KEY_W'($urandom_range(31));
    end
    if (chk_mode == MODE_IDLE) begin
      if (roll < 50) begin
        return KEY_VERIFY;
      end
      if (roll < 88) begin
        return KEY_CHANGE;
      end
      return KEY_W'($urandom_range(22));
    end
    if (chk_held >= CODE_LENGTH) begin
      if (roll < 80) begin
        return KEY_SAVE;
      end
      if (roll < 90) begin
        return KEY_BACK;
      end
      return digit_key(DIGIT_W'($urandom_range(9)));
    end
    if (roll < 15) begin
      return KEY_BACK;
    end
    if (roll < 19) begin
      return KEY_W'($urandom_range(22));
    end
    if (chk_mode != MODE_NEW && roll < 92) begin
      return digit_key(chk_code[chk_held*DIGIT_W +: DIGIT_W]);
    end
    return digit_key(DIGIT_W'($urandom_range(9)));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so that back-to-back keys need no gap.
  task automatic send_key(input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.key_index <= key;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_go && !stall_done) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
        stall_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] directed[$];
    in_ch.valid     = 1'b0;
    in_ch.key_index = '0;
    // Idle keys past the table and table keys, then a verify entry that walks the
    // empty, not-full and full buffer cases with every zero alias of the table but 0.
    directed = '{5'd23, 5'd31, 5'd0, KEY_BACK, 5'd22,
                 KEY_VERIFY, KEY_BACK, KEY_SAVE, 5'd13, 5'd31,
                 5'd11, 5'd14, 5'd15, 5'd17, 5'd18, 5'd20,
                 5'd9, KEY_BACK, 5'd21, KEY_SAVE};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_key(directed[i]);
    end
    while (acted_keys < 140) begin
      send_key(pick_key());
    end

    // Let the pipeline drain completely before the next phase.
    in_ch.valid <= 1'b0;
    while (results_owed != 0) begin
      @(negedge clk);
    end

    send_idle_pct = 55;
    recv_idle_pct <= 18;
    while (acted_keys < 270) begin
      send_key(pick_key());
    end

    // No idling; the receiver blocks once for a long stretch to back up the input.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_go <= 1'b1;
    while (acted_keys < 400) begin
      send_key(pick_key());
    end
    in_ch.valid <= 1'b0;

    while (results_owed != 0) begin
      @(negedge clk);
    end
    repeat (6) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
